### rtl/rcrg_pkg.sv
package rcrg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_WINDOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE_US   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_SHIFT_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WINDOWS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BAD_TAG      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BAD_SEQ      = 3'd6;

    // register values after reset
    localparam logic [7:0]  RST_EXPECTED_LENGTH   = 8'd8;
    localparam logic [7:0]  RST_ACCEPT_WINDOW     = 8'd16;
    localparam logic [15:0] RST_BACKOFF_BASE_US   = 16'd1000;
    localparam logic [4:0]  RST_BACKOFF_SHIFT_MAX = 5'd8;
    localparam logic [7:0]  RST_RETRY_WINDOWS     = 8'd3;
    localparam logic [7:0]  RST_CODE_BAD_TAG      = 8'd2;
    localparam logic [7:0]  RST_CODE_BAD_SEQ      = 8'd3;

    // status codes
    localparam logic [2:0] ST_EXECUTED   = 3'd0;
    localparam logic [2:0] ST_REPEAT     = 3'd1;
    localparam logic [2:0] ST_BAD_SEQ    = 3'd2;
    localparam logic [2:0] ST_TAG_ACKED  = 3'd3;
    localparam logic [2:0] ST_TAG_SILENT = 3'd4;
    localparam logic [2:0] ST_THROTTLED  = 3'd5;
    localparam logic [2:0] ST_BAD_LEN    = 3'd6;
    localparam logic [2:0] ST_EPOCH      = 3'd7;

    localparam logic       OP_COMMAND = 1'b0;
    localparam logic       OP_EPOCH   = 1'b1;

    localparam logic [7:0] RES_OK      = 8'd0;
    localparam logic [7:0] RES_ALREADY = 8'd1;

    localparam logic [7:0]  FAIL_MAX = 8'hFF;
    localparam logic [31:0] SAT_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [7:0]  page_length;
        logic [31:0] now_us;
        logic [7:0]  seq_num;
        logic [7:0]  command_code;
        logic        tag_valid;
        logic [7:0]  exec_result;
        logic [15:0] exec_value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        ack_valid;
        logic [7:0]  ack_seq;
        logic [7:0]  ack_result;
        logic [7:0]  ack_command;
        logic [15:0] ack_value;
        logic [31:0] expect_budget;
        logic [7:0]  fail_count;
    } rsp_t;

endpackage

### rtl/rcrg_stream_if.sv
interface rcrg_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/reliable_command_replay_guard.sv
// Command replay guard.
// cmd channel: one request per command page (op 0) or epoch change (op 1),
// with the page fields and the executor's answer for that command.
// rsp channel: exactly one result per request, in order: status, the
// acknowledgement to send (all zero when none), the listen budget and the
// consecutive tag failure count after that request.
// cfg port: write enable, register index and data; write only while idle.
// Requests wait in the input register; results are registered once rsp
// is free (one request per cycle while rsp is taken), in a single pass:
// input register, compare/add logic, result register. The widest path is
// the backoff shift into the 32-bit saturating deadline add.
// Reset: registers return to their default values, sequence memory, stored
// answer, backoff and budget are cleared; both channels come up empty.
// Stall: a result held on rsp keeps its value; one more request is still
// taken into the input register, after which cmd.ready drops until rsp
// is taken.
module reliable_command_replay_guard (
    input  logic                            clk,
    input  logic                            rst_n,
    rcrg_stream_if.sink                     cmd,
    rcrg_stream_if.source                   rsp,
    input  logic                            cfg_we,
    input  logic [rcrg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcrg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rcrg_pkg::*;

    // configuration
    logic [7:0]  expected_length_reg;
    logic [7:0]  accept_window_reg;
    logic [15:0] backoff_base_reg;
    logic [4:0]  backoff_shift_max_reg;
    logic [7:0]  retry_windows_reg;
    logic [7:0]  code_bad_tag_reg;
    logic [7:0]  code_bad_seq_reg;

    // guard state
    logic [7:0]  fail_counter_reg,   fail_counter_next;
    logic [31:0] blocked_until_reg,  blocked_until_next;
    logic        seq_known_reg,      seq_known_next;
    logic [7:0]  last_seq_reg,       last_seq_next;
    logic        stored_valid_reg,   stored_valid_next;
    logic [7:0]  stored_seq_reg,     stored_seq_next;
    logic [7:0]  stored_result_reg,  stored_result_next;
    logic [7:0]  stored_command_reg, stored_command_next;
    logic [15:0] stored_value_reg,   stored_value_next;
    logic [31:0] expect_left_reg,    expect_left_next;

    // pipeline
    logic        in_valid_reg;
    cmd_t        in_reg;
    logic        out_valid_reg;
    rsp_t        out_reg;
    rsp_t        out_next;
    logic        advance;

    // datapath helpers
    logic [32:0] budget_sum;
    logic [31:0] budget_sat;
    logic [7:0]  fail_inc;
    logic [7:0]  shift_raw;
    logic [4:0]  shift_amt;
    logic [46:0] backoff_shifted;
    logic [47:0] deadline_sum;
    logic [31:0] deadline_sat;
    logic [7:0]  seq_step;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_length_reg   <= RST_EXPECTED_LENGTH;
            accept_window_reg     <= RST_ACCEPT_WINDOW;
            backoff_base_reg      <= RST_BACKOFF_BASE_US;
            backoff_shift_max_reg <= RST_BACKOFF_SHIFT_MAX;
            retry_windows_reg     <= RST_RETRY_WINDOWS;
            code_bad_tag_reg      <= RST_CODE_BAD_TAG;
            code_bad_seq_reg      <= RST_CODE_BAD_SEQ;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_LENGTH:   expected_length_reg   <= cfg_wdata[7:0];
                CFG_ACCEPT_WINDOW:     accept_window_reg     <= cfg_wdata[7:0];
                CFG_BACKOFF_BASE_US:   backoff_base_reg      <= cfg_wdata[15:0];
                CFG_BACKOFF_SHIFT_MAX: backoff_shift_max_reg <= cfg_wdata[4:0];
                CFG_RETRY_WINDOWS:     retry_windows_reg     <= cfg_wdata[7:0];
                CFG_CODE_BAD_TAG:      code_bad_tag_reg      <= cfg_wdata[7:0];
                CFG_CODE_BAD_SEQ:      code_bad_seq_reg      <= cfg_wdata[7:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        budget_sum = {1'b0, expect_left_reg} + {25'd0, retry_windows_reg};
        budget_sat = budget_sum[32] ? SAT_MAX : budget_sum[31:0];

        fail_inc  = (fail_counter_reg == FAIL_MAX) ? FAIL_MAX : fail_counter_reg + 8'd1;
        shift_raw = fail_inc - 8'd1;
        shift_amt = (shift_raw > {3'd0, backoff_shift_max_reg}) ?
                    backoff_shift_max_reg : shift_raw[4:0];
        backoff_shifted = {31'd0, backoff_base_reg} << shift_amt;
        deadline_sum = {16'd0, in_reg.now_us} + {1'b0, backoff_shifted};
        deadline_sat = (deadline_sum[47:32] != 16'd0) ? SAT_MAX : deadline_sum[31:0];

        seq_step = in_reg.seq_num - last_seq_reg;
    end

    always_comb
    begin
        fail_counter_next   = fail_counter_reg;
        blocked_until_next  = blocked_until_reg;
        seq_known_next      = seq_known_reg;
        last_seq_next       = last_seq_reg;
        stored_valid_next   = stored_valid_reg;
        stored_seq_next     = stored_seq_reg;
        stored_result_next  = stored_result_reg;
        stored_command_next = stored_command_reg;
        stored_value_next   = stored_value_reg;
        expect_left_next    = expect_left_reg;

        out_next             = '0;

        if (in_reg.op == OP_EPOCH)
        begin
            seq_known_next    = 1'b0;
            stored_valid_next = 1'b0;
            last_seq_next     = 8'd0;
            out_next.status   = ST_EPOCH;
        end
        else if (in_reg.page_length != expected_length_reg)
        begin
            out_next.status = ST_BAD_LEN;
        end
        else if (fail_counter_reg != 8'd0 && in_reg.now_us < blocked_until_reg)
        begin
            out_next.status = ST_THROTTLED;
        end
        else if (!in_reg.tag_valid)
        begin
            fail_counter_next  = fail_inc;
            blocked_until_next = deadline_sat;
            if (fail_counter_reg == 8'd0)
            begin
                out_next.status      = ST_TAG_ACKED;
                out_next.ack_valid   = 1'b1;
                out_next.ack_seq     = in_reg.seq_num;
                out_next.ack_result  = code_bad_tag_reg;
                out_next.ack_command = in_reg.command_code;
            end
            else
            begin
                out_next.status = ST_TAG_SILENT;
            end
        end
        else
        begin
            fail_counter_next  = 8'd0;
            blocked_until_next = 32'd0;
            expect_left_next   = budget_sat;
            out_next.ack_valid = 1'b1;
            if (seq_known_reg && in_reg.seq_num == last_seq_reg && stored_valid_reg)
            begin
                out_next.status      = ST_REPEAT;
                out_next.ack_seq     = stored_seq_reg;
                out_next.ack_result  = (stored_result_reg == RES_OK) ?
                                       RES_ALREADY : stored_result_reg;
                out_next.ack_command = stored_command_reg;
                out_next.ack_value   = stored_value_reg;
            end
            else if (seq_known_reg && (seq_step == 8'd0 || seq_step > accept_window_reg))
            begin
                out_next.status      = ST_BAD_SEQ;
                out_next.ack_seq     = in_reg.seq_num;
                out_next.ack_result  = code_bad_seq_reg;
                out_next.ack_command = in_reg.command_code;
            end
            else
            begin
                out_next.status      = ST_EXECUTED;
                out_next.ack_seq     = in_reg.seq_num;
                out_next.ack_result  = in_reg.exec_result;
                out_next.ack_command = in_reg.command_code;
                out_next.ack_value   = in_reg.exec_value;
                last_seq_next        = in_reg.seq_num;
                seq_known_next       = 1'b1;
                stored_valid_next    = 1'b1;
                stored_seq_next      = in_reg.seq_num;
                stored_result_next   = in_reg.exec_result;
                stored_command_next  = in_reg.command_code;
                stored_value_next    = in_reg.exec_value;
            end
        end

        out_next.expect_budget = expect_left_next;
        out_next.fail_count    = fail_counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_counter_reg   <= 8'd0;
            blocked_until_reg  <= 32'd0;
            seq_known_reg      <= 1'b0;
            last_seq_reg       <= 8'd0;
            stored_valid_reg   <= 1'b0;
            stored_seq_reg     <= 8'd0;
            stored_result_reg  <= 8'd0;
            stored_command_reg <= 8'd0;
            stored_value_reg   <= 16'd0;
            expect_left_reg    <= 32'd0;
        end
        else if (advance)
        begin
            fail_counter_reg   <= fail_counter_next;
            blocked_until_reg  <= blocked_until_next;
            seq_known_reg      <= seq_known_next;
            last_seq_reg       <= last_seq_next;
            stored_valid_reg   <= stored_valid_next;
            stored_seq_reg     <= stored_seq_next;
            stored_result_reg  <= stored_result_next;
            stored_command_reg <= stored_command_next;
            stored_value_reg   <= stored_value_next;
            expect_left_reg    <= expect_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_reg <= cmd.payload;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // rejections without an acknowledgement carry all-zero ack fields
    a_silent_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status == ST_TAG_SILENT || out_reg.status == ST_THROTTLED
            || out_reg.status == ST_BAD_LEN || out_reg.status == ST_EPOCH)
        |-> !out_reg.ack_valid && out_reg.ack_seq == 8'd0 && out_reg.ack_value == 16'd0)
        else $error("silent result carries an acknowledgement");

    // only the first failure is acknowledged, so the count is then one
    a_first_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_TAG_ACKED |-> out_reg.fail_count == 8'd1)
        else $error("acknowledged tag failure with wrong fail count");

    // an epoch request leaves no known sequence and no stored answer
    a_epoch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_reg.op == OP_EPOCH |=> !seq_known_reg && !stored_valid_reg)
        else $error("epoch did not clear sequence memory");

    // a held result with a full input register must back-pressure cmd
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready && in_valid_reg |-> !cmd.ready)
        else $error("request taken while both registers are full");

    // a stalled result must not be overwritten
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

endmodule
